>>> src/uart_tx_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uart_tx_pkg
// Shared types and constants for the queued 8N1 UART transmitter.
// ----------------------------------------------------------------------------
package uart_tx_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int PTR_W       = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int DATA_BITS   = 8;
    localparam int CNT_W       = 4;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_BREAK = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic tx_pin;
        logic write_dropped;
        logic busy_res;
    } t_out_word;

endpackage
`default_nettype wire

>>> src/uart_transmitter_with_queue.sv
`default_nettype none
// A result word is registered and appears the cycle after its input is taken.
// Throughput: one word per cycle unless the output stalls; the register lets
// a new word enter in the same cycle that the waiting result is taken.
// Reset clears the pointers, the frame machine and the line level (mark); the
// queue entries are undefined until written. Configuration is always ready.
// ----------------------------------------------------------------------------
// uart_transmitter_with_queue
// Ring queue feeding an 8N1 frame machine that advances on bit-time ticks.
// ----------------------------------------------------------------------------
module uart_transmitter_with_queue (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire uart_tx_pkg::t_in_word i_in_word,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output uart_tx_pkg::t_out_word o_out_word,
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire                   i_cfg_data
);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_START = 2'd1;
    localparam logic [1:0] PH_DATA  = 2'd2;
    localparam logic [1:0] PH_STOP  = 2'd3;

    localparam logic [uart_tx_pkg::PTR_W-1:0] PTR_LAST =
        uart_tx_pkg::PTR_W'(uart_tx_pkg::QUEUE_DEPTH - 1);
    localparam logic [uart_tx_pkg::CNT_W-1:0] CNT_DONE =
        uart_tx_pkg::CNT_W'(uart_tx_pkg::DATA_BITS);

    logic [7:0]                      r_queue [uart_tx_pkg::QUEUE_DEPTH];
    logic [uart_tx_pkg::PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [uart_tx_pkg::PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [1:0]                      r_phase, n_phase;
    logic [7:0]                      r_shift_byte;
    logic [uart_tx_pkg::CNT_W-1:0]   r_bits_sent, n_bits_sent;
    logic                            r_line_level, n_line_level;
    logic                            r_invert;
    logic                            r_out_valid;
    uart_tx_pkg::t_out_word          r_out_word, n_out_word;

    logic                            in_accept;
    logic [uart_tx_pkg::PTR_W-1:0]   wr_next;
    logic [uart_tx_pkg::PTR_W-1:0]   rd_next;
    logic                            do_write;
    logic                            do_load;
    logic                            do_shift;
    logic                            dropped;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_accept   = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign wr_next = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
    assign rd_next = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;

    always_comb begin
        n_wr_ptr     = r_wr_ptr;
        n_rd_ptr     = r_rd_ptr;
        n_phase      = r_phase;
        n_bits_sent  = r_bits_sent;
        n_line_level = r_line_level;
        do_write     = 1'b0;
        do_load      = 1'b0;
        do_shift     = 1'b0;
        dropped      = 1'b0;
        case (i_in_word.kind)
            uart_tx_pkg::KIND_WRITE: begin
                if (wr_next != r_rd_ptr) begin
                    do_write = 1'b1;
                    n_wr_ptr = wr_next;
                end else begin
                    dropped = 1'b1;
                end
            end
            uart_tx_pkg::KIND_TICK: begin
                unique case (r_phase)
                    PH_IDLE: begin
                        if (r_wr_ptr != r_rd_ptr) begin
                            do_load     = 1'b1;
                            n_rd_ptr    = rd_next;
                            n_phase     = PH_START;
                            n_bits_sent = '0;
                        end
                    end
                    PH_START: begin
                        n_line_level = 1'b0;
                        n_phase      = PH_DATA;
                    end
                    PH_DATA: begin
                        do_shift     = 1'b1;
                        n_line_level = r_shift_byte[0];
                        n_bits_sent  = r_bits_sent + 1'b1;
                        if (n_bits_sent >= CNT_DONE) begin
                            n_phase = PH_STOP;
                        end
                    end
                    default: begin
                        n_line_level = 1'b1;
                        n_phase      = PH_IDLE;
                    end
                endcase
            end
            uart_tx_pkg::KIND_BREAK: begin
                n_wr_ptr = '0;
                n_rd_ptr = '0;
                n_phase  = PH_IDLE;
            end
            default: begin
            end
        endcase
        n_out_word.tx_pin        = n_line_level ^ r_invert;
        n_out_word.write_dropped = dropped;
        n_out_word.busy_res      = (n_phase != PH_IDLE) || (n_wr_ptr != n_rd_ptr);
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && do_write) begin
            r_queue[r_wr_ptr] <= i_in_word.data_byte;
        end
        if (!i_rst_n) begin
            r_shift_byte <= '0;
        end else if (in_accept && do_load) begin
            r_shift_byte <= r_queue[r_rd_ptr];
        end else if (in_accept && do_shift) begin
            r_shift_byte <= {1'b0, r_shift_byte[7:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_phase      <= PH_IDLE;
            r_bits_sent  <= '0;
            r_line_level <= 1'b1;
            r_invert     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_invert <= i_cfg_data;
            end
            if (in_accept) begin
                r_wr_ptr     <= n_wr_ptr;
                r_rd_ptr     <= n_rd_ptr;
                r_phase      <= n_phase;
                r_bits_sent  <= n_bits_sent;
                r_line_level <= n_line_level;
                r_out_valid  <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_word <= n_out_word;
        end
    end

`ifndef SYNTH
    // A dropped write means the queue was full, so the block must report busy.
    a_drop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_word.write_dropped) |-> r_out_word.busy_res)
        else $error("dropped write reported while not busy");

    // The data phase never runs past eight bits.
    a_bits_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_bits_sent < CNT_DONE))
        else $error("bit counter overran in data phase");

    // A break empties the queue and idles the frame machine.
    a_break_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_word.kind == uart_tx_pkg::KIND_BREAK) |=>
        (r_wr_ptr == '0 && r_rd_ptr == '0 && r_phase == PH_IDLE && r_out_valid))
        else $error("break did not flush the queue");

    // The start bit always follows a load from the queue.
    a_start_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_phase == PH_START) |-> (r_bits_sent == '0))
        else $error("start phase entered without a load");
`endif

endmodule
`default_nettype wire
